// ----- hdl/quoted_printable_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// quoted-printable decoder assertion macros
// shared property forms for the decoder checks, clocked on clk and held off
// while arst_n is low
// ----------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_DECODER_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_MACROS_SVH

// same-cycle implication
`define QPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/qpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_pkg
// types, character codes, status codes and the hex digit decode shared by
// the quoted-printable decoder modules
// ----------------------------------------------------------------------------
package qpd_pkg;

	// decoder modes
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_BLANKS = 3'd1,
		MODE_EQ     = 3'd2,
		MODE_EQ_HEX = 3'd3,
		MODE_CR     = 3'd4,
		MODE_EQ_CR  = 3'd5
	} mode_t;

	// controller states
	typedef enum logic {
		FSM_IDLE  = 1'b0,
		FSM_BURST = 1'b1
	} fsm_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_full;
		logic burst_start;
		logic more;
	} sts_t;

	// status codes
	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_BLANKS = 3'd1;
	localparam logic [2:0] STAT_HEX    = 3'd2;
	localparam logic [2:0] STAT_CR     = 3'd3;
	localparam logic [2:0] STAT_EOS_EQ = 3'd4;
	localparam logic [2:0] STAT_EOS_CR = 3'd5;

	// character codes
	localparam logic [7:0] CHAR_EQ  = 8'h3D;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_SP  = 8'h20;

	// hex digit decode: {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ----- hdl/quoted_printable_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_decoder
// quoted-printable byte stream decoder with held blank runs and sticky errors
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// input   | in_valid / in_stall  | byte_in, end_of_stream
// output  | out_valid / out_stall| out_byte, byte_valid, status, last_of_run
//
// a held run of N blanks ended by an ordinary byte flushes one result per cycle
// from the blank store read port and the held byte while the output is not
// stalled, with the input stalled meanwhile.
// reset clears mode, counters, error and output valid; the blank store needs
// no clearing pass since only written entries are read.
// a new transfer is taken while the output register drains in the same cycle.
// ----------------------------------------------------------------------------
`include "quoted_printable_decoder_macros.svh"

module quoted_printable_decoder #(
	parameter int MAX_BLANKS = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [2:0] status,
	output logic       last_of_run
);

	qpd_pkg::cmd_t cmd;
	qpd_pkg::sts_t sts;

	// controller
	qpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	qpd_datapath #(
		.MAX_BLANKS(MAX_BLANKS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_in      (byte_in),
		.end_of_stream(end_of_stream),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.status       (status),
		.last_of_run  (last_of_run)
	);

	// checks
	`QPD_ASSERT_NOW(a_flush_blocks_input, cmd.emit, in_stall, "input taken during flush")
	`QPD_ASSERT_NOW(a_quiet_zero, out_valid && !byte_valid, out_byte == 8'd0, "quiet result not zero")
	`QPD_ASSERT_NEXT(a_eos_single, in_valid && !in_stall && end_of_stream, out_valid && last_of_run && !byte_valid, "end of stream result wrong")
	`QPD_ASSERT_NEXT(a_error_sticky, out_valid && !out_stall && status != qpd_pkg::STAT_OK, !(out_valid && byte_valid), "byte after error")

endmodule

// ----- hdl/qpd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module qpd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 63
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/qpd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_ctrl
// controller: takes input transfers and paces the flush of a held blank run
// ----------------------------------------------------------------------------
module qpd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          out_stall,
	input  qpd_pkg::sts_t sts,
	output qpd_pkg::cmd_t cmd
);

	qpd_pkg::fsm_t state_q;
	qpd_pkg::fsm_t state_nxt;
	logic          out_free;

	// output register empty or draining this cycle
	assign out_free = !sts.out_full || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpd_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			qpd_pkg::FSM_IDLE: begin
				if (in_valid && out_free && sts.burst_start) begin
					state_nxt = qpd_pkg::FSM_BURST;
				end
			end
			qpd_pkg::FSM_BURST: begin
				if (out_free && !sts.more) begin
					state_nxt = qpd_pkg::FSM_IDLE;
				end
			end
			default: state_nxt = qpd_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.emit   = 1'b0;
		unique case (state_q)
			qpd_pkg::FSM_IDLE: begin
				in_stall   = !out_free;
				cmd.accept = in_valid && out_free;
			end
			qpd_pkg::FSM_BURST: begin
				cmd.emit = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

// ----- hdl/qpd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_datapath
// decoder state, blank run store, burst index and output register
// ----------------------------------------------------------------------------
module qpd_datapath #(
	parameter int MAX_BLANKS = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    byte_in,
	input  logic          end_of_stream,
	input  qpd_pkg::cmd_t cmd,
	output qpd_pkg::sts_t sts,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic [2:0]    status,
	output logic          last_of_run
);

	localparam int CW = $clog2(MAX_BLANKS + 1);
	localparam int IW = (MAX_BLANKS > 1) ? $clog2(MAX_BLANKS) : 1;

	// decoder state
	qpd_pkg::mode_t mode_q;
	logic [CW-1:0]  count_q;
	logic [3:0]     nib_q;
	logic [2:0]     err_q;

	// burst state
	logic [CW-1:0]  idx_q;
	logic [7:0]     pend_q;
	logic           pend_valid_q;
	// first held blank, kept apart since the store read is registered
	logic           tab0_q;

	// output register
	logic           ovalid_q;
	logic [7:0]     obyte_q;
	logic           obv_q;
	logic [2:0]     ostat_q;
	logic           olast_q;

	// accept path
	qpd_pkg::mode_t n_mode;
	logic [CW-1:0]  n_count;
	logic [3:0]     n_nib;
	logic [2:0]     n_err;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	logic           wr_tab;
	logic [7:0]     a_byte;
	logic           a_bv;
	logic           a_pend_valid;
	logic           burst_start;
	logic           is_blank;
	logic           is_tab;
	logic [4:0]     hx;

	// burst path
	logic           rd_tab;
	logic [IW-1:0]  rd_addr;
	logic [CW-1:0]  idx_plus;
	logic [CW-1:0]  nxt_idx;
	logic           e_in_run;
	logic [7:0]     e_byte;
	logic           e_last;

	assign is_tab   = (byte_in == qpd_pkg::CHAR_TAB);
	assign is_blank = is_tab || (byte_in == qpd_pkg::CHAR_SP);
	assign hx       = qpd_pkg::hex_decode(byte_in);

	// decode of one accepted byte
	always_comb begin
		n_mode       = mode_q;
		n_count      = count_q;
		n_nib        = nib_q;
		n_err        = err_q;
		wr_en        = 1'b0;
		wr_addr      = count_q[IW-1:0];
		wr_tab       = is_tab;
		a_byte       = 8'd0;
		a_bv         = 1'b0;
		a_pend_valid = 1'b0;
		burst_start  = 1'b0;
		if (err_q != qpd_pkg::STAT_OK) begin
			n_err = err_q;
		end else if (end_of_stream) begin
			if (mode_q == qpd_pkg::MODE_EQ || mode_q == qpd_pkg::MODE_EQ_HEX ||
			    mode_q == qpd_pkg::MODE_EQ_CR) begin
				n_err = qpd_pkg::STAT_EOS_EQ;
			end else if (mode_q == qpd_pkg::MODE_CR) begin
				n_err = qpd_pkg::STAT_EOS_CR;
			end else begin
				n_mode  = qpd_pkg::MODE_NORMAL;
				n_count = '0;
			end
		end else begin
			unique case (mode_q)
				qpd_pkg::MODE_BLANKS: begin
					if (is_blank) begin
						if (count_q < CW'(MAX_BLANKS)) begin
							wr_en   = 1'b1;
							n_count = count_q + CW'(1);
						end else begin
							n_err = qpd_pkg::STAT_BLANKS;
						end
					end else if (byte_in == qpd_pkg::CHAR_CR) begin
						n_count = '0;
						n_mode  = qpd_pkg::MODE_CR;
					end else if (byte_in == qpd_pkg::CHAR_LF) begin
						n_count = '0;
						n_mode  = qpd_pkg::MODE_NORMAL;
						a_byte  = qpd_pkg::CHAR_LF;
						a_bv    = 1'b1;
					end else begin
						// first held blank goes out now, the rest follow
						a_byte = tab0_q ? qpd_pkg::CHAR_TAB : qpd_pkg::CHAR_SP;
						a_bv   = 1'b1;
						if (byte_in == qpd_pkg::CHAR_EQ) begin
							n_mode = qpd_pkg::MODE_EQ;
						end else begin
							n_mode       = qpd_pkg::MODE_NORMAL;
							a_pend_valid = 1'b1;
						end
						burst_start = (count_q > CW'(1)) || a_pend_valid;
					end
				end
				qpd_pkg::MODE_EQ: begin
					if (byte_in == qpd_pkg::CHAR_LF) begin
						n_mode = qpd_pkg::MODE_NORMAL;
					end else if (byte_in == qpd_pkg::CHAR_CR) begin
						n_mode = qpd_pkg::MODE_EQ_CR;
					end else if (hx[4]) begin
						n_nib  = hx[3:0];
						n_mode = qpd_pkg::MODE_EQ_HEX;
					end else begin
						n_err = qpd_pkg::STAT_HEX;
					end
				end
				qpd_pkg::MODE_EQ_HEX: begin
					if (hx[4]) begin
						a_byte = {nib_q, hx[3:0]};
						a_bv   = 1'b1;
						n_mode = qpd_pkg::MODE_NORMAL;
					end else begin
						n_err = qpd_pkg::STAT_HEX;
					end
				end
				qpd_pkg::MODE_CR: begin
					if (byte_in == qpd_pkg::CHAR_LF) begin
						a_byte = qpd_pkg::CHAR_LF;
						a_bv   = 1'b1;
						n_mode = qpd_pkg::MODE_NORMAL;
					end else begin
						n_err = qpd_pkg::STAT_CR;
					end
				end
				qpd_pkg::MODE_EQ_CR: begin
					if (byte_in == qpd_pkg::CHAR_LF) begin
						n_mode = qpd_pkg::MODE_NORMAL;
					end else begin
						n_err = qpd_pkg::STAT_CR;
					end
				end
				default: begin
					// normal mode
					n_mode = qpd_pkg::MODE_NORMAL;
					if (is_blank) begin
						n_mode  = qpd_pkg::MODE_BLANKS;
						n_count = CW'(1);
						wr_en   = 1'b1;
						wr_addr = '0;
					end else if (byte_in == qpd_pkg::CHAR_EQ) begin
						n_mode = qpd_pkg::MODE_EQ;
					end else if (byte_in == qpd_pkg::CHAR_CR) begin
						n_mode = qpd_pkg::MODE_CR;
					end else begin
						a_byte = byte_in;
						a_bv   = 1'b1;
					end
				end
			endcase
		end
	end

	// next item of a blank run flush
	assign idx_plus = idx_q + CW'(1);
	assign e_in_run = idx_q < count_q;
	assign e_byte   = e_in_run ? (rd_tab ? qpd_pkg::CHAR_TAB : qpd_pkg::CHAR_SP) : pend_q;
	assign e_last   = e_in_run ? ((idx_plus == count_q) && !pend_valid_q) : 1'b1;

	// burst index and store read address, one entry ahead of the output
	always_comb begin
		nxt_idx = idx_q;
		if (cmd.accept && burst_start) begin
			nxt_idx = CW'(1);
		end else if (cmd.emit) begin
			nxt_idx = e_last ? '0 : idx_plus;
		end
	end
	assign rd_addr = (nxt_idx < CW'(MAX_BLANKS)) ? nxt_idx[IW-1:0] : '0;

	// blank run store, one bit per held blank (set for a tab)
	qpd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLANKS)
	) u_blank_ram (
		.clk  (clk),
		.we   (cmd.accept && wr_en),
		.waddr(wr_addr),
		.wdata(wr_tab),
		.raddr(rd_addr),
		.rdata(rd_tab)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= qpd_pkg::MODE_NORMAL;
			count_q      <= '0;
			nib_q        <= 4'd0;
			err_q        <= qpd_pkg::STAT_OK;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			idx_q <= nxt_idx;
			if (cmd.accept) begin
				mode_q  <= n_mode;
				count_q <= n_count;
				nib_q   <= n_nib;
				err_q   <= n_err;
				if (burst_start) begin
					pend_valid_q <= a_pend_valid;
				end
			end
			if (cmd.accept || cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && burst_start) begin
			pend_q <= byte_in;
		end
		if (cmd.accept && wr_en && (wr_addr == '0)) begin
			tab0_q <= wr_tab;
		end
		if (cmd.accept) begin
			obyte_q <= a_byte;
			obv_q   <= a_bv;
			ostat_q <= n_err;
			olast_q <= !burst_start;
		end else if (cmd.emit) begin
			obyte_q <= e_byte;
			obv_q   <= 1'b1;
			ostat_q <= err_q;
			olast_q <= e_last;
		end
	end

	// status to controller
	assign sts.out_full    = ovalid_q;
	assign sts.burst_start = burst_start;
	assign sts.more        = !e_last;

	assign out_valid   = ovalid_q;
	assign out_byte    = obyte_q;
	assign byte_valid  = obv_q;
	assign status      = ostat_q;
	assign last_of_run = olast_q;

endmodule
